>>> sv/laser_scan_to_points_macros.svh
// Assertion macros used by the checker file.
`ifndef LASER_SCAN_TO_POINTS_MACROS_SVH
`define LASER_SCAN_TO_POINTS_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is held.
`define LSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also across reset.
`define LSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/lsp_pkg.sv
`timescale 1ns / 1ps

package lsp_pkg;

    // Field widths
    localparam int ANGLE_W    = 16;
    localparam int RANGE_W    = 16;
    localparam int TAG_W      = 16;
    localparam int BCOUNT_W   = 11;
    localparam int BEAM_IDX_W = 10;
    localparam int OUT_W      = 17;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Default parameter values
    localparam int MAX_BEAMS_DEF   = 1024;
    localparam int TRIG_STAGES_DEF = 16;

    // CORDIC datapath widths: range scaled by 2^14 plus gain growth and sign
    localparam int RANGE_SHIFT = 14;
    localparam int XY_W        = 33;
    localparam int GAIN_W      = 18;
    localparam int PROD_W      = XY_W + GAIN_W;
    localparam int ROUND_SH    = 30;
    localparam int QUOT_W      = PROD_W - ROUND_SH;

    // Gain compensation 39797 / 2^16 and round-half-up offset
    localparam logic signed [GAIN_W-1:0] GAIN_COMP  = 18'sd39797;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SH - 1);
    localparam logic signed [QUOT_W:0]   SAT_MAX    = (QUOT_W + 1)'(65535);
    localparam logic signed [QUOT_W:0]   SAT_MIN    = -SAT_MAX;

    // Reset values of the configuration registers
    localparam logic [RANGE_W-1:0]  THRESH_RST = 16'hFFFF;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 11'd1024;

    // Arctangent of 2^-i in 32-bit turn units
    localparam int ATAN_N = 24;
    localparam logic [29:0] ATAN_TAB [0:ATAN_N-1] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE,
        REG_ANGLE_STEP,
        REG_RANGE_THRESH,
        REG_BEAM_COUNT
    } cfg_reg_t;

    // Fields that ride along the CORDIC pipeline
    typedef struct packed {
        logic [TAG_W-1:0]      tag;
        logic                  kept;
        logic [BEAM_IDX_W-1:0] index;
        logic                  last;
        logic                  neg;
    } side_t;

    // Arctangent for a stage; stages past the table add nothing
    function automatic logic [29:0] atan_at(input int i);
        logic [29:0] val;
        val = '0;
        if (i < ATAN_N) begin
            val = ATAN_TAB[i];
        end
        return val;
    endfunction

endpackage

>>> sv/laser_scan_to_points.sv
`timescale 1ns / 1ps

// Laser scan to Cartesian points.
// Input channel (s_valid/s_ready): one range sample and its scan tag per
// transaction. Output channel (m_valid/m_ready): one point per sample with
// x, y in signed Q17.0, kept flag, beam index, tag and last-of-scan flag.
// Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_index
// (0 start angle, 1 angle step, 2 range threshold, 3 beam count); write only
// while no samples are in flight.
// Path: an accepted sample passes the input register, one register per
// CORDIC stage, the gain multiplier register and the output register
// before it shows on m_valid.
// Throughput: one sample per cycle while the output is not stalled; the CORDIC is fully pipelined.
// Stall: empty pipeline slots close up; with all slots and the output
// register full, s_ready drops until m_ready takes the held point.
// Reset: synchronous, active low; clears the beam counter, the angle
// accumulator, all valid flags and loads register defaults.
module laser_scan_to_points
    import lsp_pkg::*;
#(
    parameter int MAX_BEAMS   = MAX_BEAMS_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    // range samples
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [RANGE_W-1:0]           s_range,
    input  logic [TAG_W-1:0]             s_scan_tag,
    // points
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_W-1:0]      m_point_x,
    output logic signed [OUT_W-1:0]      m_point_y,
    output logic                         m_kept,
    output logic [BEAM_IDX_W-1:0]        m_beam_index,
    output logic [TAG_W-1:0]             m_tag_out,
    output logic                         m_last_of_scan
);

    localparam int CNT_W = $clog2(MAX_BEAMS);
    localparam int CMP_W = ($clog2(MAX_BEAMS + 1) > BCOUNT_W) ?
                           $clog2(MAX_BEAMS + 1) : BCOUNT_W;
    localparam int LAST  = TRIG_STAGES + 1;

    // Configuration registers
    logic [ANGLE_W-1:0]  start_angle_reg;
    logic [ANGLE_W-1:0]  angle_step_reg;
    logic [RANGE_W-1:0]  range_thresh_reg;
    logic [BCOUNT_W-1:0] beam_count_reg;

    // Scan state
    logic [CNT_W-1:0]    beam_cnt_reg;
    logic [CNT_W-1:0]    beam_cnt_next;
    logic [ANGLE_W-1:0]  angle_acc_reg;
    logic [ANGLE_W-1:0]  angle_acc_next;

    // Pipeline slots: 0 input, 1..TRIG_STAGES CORDIC, LAST gain multiply
    logic [LAST:0]             valid_reg;
    logic [LAST:0]             valid_next;
    logic [LAST:0]             slot_rdy;
    logic [LAST+1:0]           rdy_chain;
    logic [LAST:0]             in_valid;
    logic signed [XY_W-1:0]    x_reg [0:TRIG_STAGES];
    logic signed [XY_W-1:0]    y_reg [0:TRIG_STAGES];
    logic signed [XY_W-1:0]    z_reg [0:TRIG_STAGES];
    side_t                     side_reg [0:LAST];
    logic signed [PROD_W-1:0]  mx_reg;
    logic signed [PROD_W-1:0]  my_reg;

    // Output register
    logic                      m_valid_reg;
    logic signed [OUT_W-1:0]   point_x_reg;
    logic signed [OUT_W-1:0]   point_y_reg;
    side_t                     out_side_reg;
    logic                      out_take;

    // Per-sample front end
    logic                      s_xfer;
    logic [ANGLE_W-1:0]        beam_angle;
    logic [ANGLE_W-1:0]        angle_fold;
    logic                      quad_neg;
    logic [CMP_W-1:0]          bc_ext;
    logic [CMP_W-1:0]          bc_eff;
    logic [CMP_W-1:0]          cnt_ext;
    logic                      is_last;
    side_t                     side_in;

    // Round, undo the half-turn fold, and saturate one coordinate
    function automatic logic signed [OUT_W-1:0] finish_val(
        input logic signed [PROD_W-1:0] prod,
        input logic                     neg
    );
        logic signed [PROD_W-1:0] sum;
        logic signed [QUOT_W-1:0] quot;
        logic signed [QUOT_W:0]   res;
        logic signed [OUT_W-1:0]  sat;
        sum  = prod + ROUND_HALF;
        quot = sum[PROD_W-1:ROUND_SH];
        res  = neg ? -(QUOT_W + 1)'(quot) : (QUOT_W + 1)'(quot);
        if (res > SAT_MAX) begin
            sat = OUT_W'(SAT_MAX);
        end else if (res < SAT_MIN) begin
            sat = OUT_W'(SAT_MIN);
        end else begin
            sat = OUT_W'(res);
        end
        return sat;
    endfunction

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg  <= '0;
            angle_step_reg   <= '0;
            range_thresh_reg <= THRESH_RST;
            beam_count_reg   <= BCOUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_START_ANGLE:  start_angle_reg  <= cfg_wdata[ANGLE_W-1:0];
                REG_ANGLE_STEP:   angle_step_reg   <= cfg_wdata[ANGLE_W-1:0];
                REG_RANGE_THRESH: range_thresh_reg <= cfg_wdata[RANGE_W-1:0];
                REG_BEAM_COUNT:   beam_count_reg   <= cfg_wdata[BCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Resolve beam angle, position in scan and the sideband of a new sample
    always_comb begin
        s_xfer     = s_valid && s_ready;
        beam_angle = (beam_cnt_reg == '0) ? start_angle_reg : angle_acc_reg;
        quad_neg   = beam_angle[ANGLE_W-1] ^ beam_angle[ANGLE_W-2];
        angle_fold = {beam_angle[ANGLE_W-1] ^ quad_neg, beam_angle[ANGLE_W-2:0]};

        bc_ext = CMP_W'(beam_count_reg);
        if (bc_ext == '0) begin
            bc_eff = CMP_W'(1);
        end else if (bc_ext > CMP_W'(MAX_BEAMS)) begin
            bc_eff = CMP_W'(MAX_BEAMS);
        end else begin
            bc_eff = bc_ext;
        end
        cnt_ext = CMP_W'(beam_cnt_reg);
        is_last = cnt_ext >= (bc_eff - CMP_W'(1));

        side_in.tag   = s_scan_tag;
        side_in.kept  = s_range < range_thresh_reg;
        side_in.index = cnt_ext[BEAM_IDX_W-1:0];
        side_in.last  = is_last;
        side_in.neg   = quad_neg;

        beam_cnt_next  = beam_cnt_reg;
        angle_acc_next = angle_acc_reg;
        if (s_xfer) begin
            beam_cnt_next  = is_last ? '0 : beam_cnt_reg + CNT_W'(1);
            angle_acc_next = beam_angle + angle_step_reg;
        end
    end

    // Advance scan state on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_cnt_reg  <= '0;
            angle_acc_reg <= '0;
        end else begin
            beam_cnt_reg  <= beam_cnt_next;
            angle_acc_reg <= angle_acc_next;
        end
    end

    // Slot handshake: a slot loads when empty or when its content moves on
    always_comb begin
        out_take        = !m_valid_reg || m_ready;
        rdy_chain[LAST+1] = out_take;
        for (int k = LAST; k >= 0; k--) begin
            slot_rdy[k]  = !valid_reg[k] || rdy_chain[k+1];
            rdy_chain[k] = slot_rdy[k];
        end
        in_valid = {valid_reg[LAST-1:0], s_valid};
        for (int k = 0; k <= LAST; k++) begin
            valid_next[k] = slot_rdy[k] ? in_valid[k] : valid_reg[k];
        end
        s_ready = slot_rdy[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (out_take) begin
                m_valid_reg <= valid_reg[LAST];
            end
        end
    end

    // Input slot: load the starting CORDIC vector (range, 0) and folded angle
    always_ff @(posedge aclk) begin
        if (slot_rdy[0]) begin
            x_reg[0]    <= $signed(XY_W'({s_range, RANGE_SHIFT'(0)}));
            y_reg[0]    <= '0;
            z_reg[0]    <= XY_W'($signed({angle_fold, 16'd0}));
            side_reg[0] <= side_in;
        end
    end

    // CORDIC rotation stages, one micro-rotation per slot
    for (genvar k = 1; k <= TRIG_STAGES; k++) begin : g_cordic
        localparam int                     SH     = k - 1;
        localparam logic signed [XY_W-1:0] ATAN_K = XY_W'(atan_at(k - 1));

        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;

        assign dx = y_reg[k-1] >>> SH;
        assign dy = x_reg[k-1] >>> SH;

        always_ff @(posedge aclk) begin
            if (slot_rdy[k]) begin
                if (!z_reg[k-1][XY_W-1]) begin
                    x_reg[k] <= x_reg[k-1] - dx;
                    y_reg[k] <= y_reg[k-1] + dy;
                    z_reg[k] <= z_reg[k-1] - ATAN_K;
                end else begin
                    x_reg[k] <= x_reg[k-1] + dx;
                    y_reg[k] <= y_reg[k-1] - dy;
                    z_reg[k] <= z_reg[k-1] + ATAN_K;
                end
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Gain compensation multiply
    always_ff @(posedge aclk) begin
        if (slot_rdy[LAST]) begin
            mx_reg         <= x_reg[TRIG_STAGES] * GAIN_COMP;
            my_reg         <= y_reg[TRIG_STAGES] * GAIN_COMP;
            side_reg[LAST] <= side_reg[TRIG_STAGES];
        end
    end

    // Output register: round, fold back and saturate
    always_ff @(posedge aclk) begin
        if (out_take) begin
            point_x_reg  <= finish_val(mx_reg, side_reg[LAST].neg);
            point_y_reg  <= finish_val(my_reg, side_reg[LAST].neg);
            out_side_reg <= side_reg[LAST];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point_x      = point_x_reg;
    assign m_point_y      = point_y_reg;
    assign m_kept         = out_side_reg.kept;
    assign m_beam_index   = out_side_reg.index;
    assign m_tag_out      = out_side_reg.tag;
    assign m_last_of_scan = out_side_reg.last;

endmodule

>>> sv/lsp_checker.sv
`timescale 1ns / 1ps

`include "laser_scan_to_points_macros.svh"

module lsp_checker
    import lsp_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [OUT_W-1:0] m_point_x,
    input logic signed [OUT_W-1:0] m_point_y,
    input logic                    m_kept,
    input logic [BEAM_IDX_W-1:0]   m_beam_index,
    input logic [TAG_W-1:0]        m_tag_out,
    input logic                    m_last_of_scan
);

    // Reset empties the output register
    `LSP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "m_valid after reset")

    // A stalled point holds until taken
    `LSP_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable({m_point_x, m_point_y, m_kept, m_beam_index, m_tag_out, m_last_of_scan}), "stalled point changed")

    // Saturation keeps coordinates within plus or minus 65535
    `LSP_ASSERT(a_sat_range, aclk, aresetn, m_valid |-> (m_point_x != -17'sd65536) && (m_point_y != -17'sd65536), "coordinate out of range")

    // With the output register empty the pipeline always has room
    `LSP_ASSERT(a_ready_free, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty output")

endmodule

bind laser_scan_to_points lsp_checker u_lsp_checker (.*);
